@@ sv/sparse_coo_matrix_add_assert.svh @@
// Assertion macros for the sparse matrix adder.
// Both macros sample on the rising edge of clk_i and are disabled in reset.
`ifndef SPARSE_COO_MATRIX_ADD_ASSERT_SVH
`define SPARSE_COO_MATRIX_ADD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sca_pkg.sv @@
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types and codes of the sparse coordinate-list matrix adder.
// ----------------------------------------------------------------------------
package sca_pkg;

  // Field widths.
  localparam int unsigned CmdW    = 2;
  localparam int unsigned IdxW    = 16;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // Command codes of an input word.
  localparam logic [CmdW-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CmdW-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CmdW-1:0] CMD_START  = 2'd2;

  // Status codes of an output word.
  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd1;
  localparam logic [StatW-1:0] STAT_DIM   = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COLS_A = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROWS_B = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_COLS_B = 2'd3;

  // Saturation limits of a summed value.
  localparam logic signed [ValW-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ValW-1:0] VAL_MIN = 32'sh8000_0000;

  // One stored triplet.
  typedef struct packed {
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        col;
    logic signed [ValW-1:0] value;
  } entry_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

endpackage

@@ sv/sca_in_if.sv @@
// ----------------------------------------------------------------------------
// sca_in_if
// Input channel of the matrix adder: one command word per handshake.
// ----------------------------------------------------------------------------
interface sca_in_if;
  logic                                valid;
  logic                                ready;
  logic [sca_pkg::CmdW-1:0]            cmd;
  logic [sca_pkg::IdxW-1:0]            row;
  logic [sca_pkg::IdxW-1:0]            col;
  logic signed [sca_pkg::ValW-1:0]     value;

  modport source (output valid, cmd, row, col, value, input ready);
  modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

@@ sv/sca_out_if.sv @@
// ----------------------------------------------------------------------------
// sca_out_if
// Output channel of the matrix adder: one result triplet per handshake.
// ----------------------------------------------------------------------------
interface sca_out_if;
  logic                                valid;
  logic                                ready;
  logic [sca_pkg::IdxW-1:0]            out_row;
  logic [sca_pkg::IdxW-1:0]            out_col;
  logic signed [sca_pkg::ValW-1:0]     out_value;
  logic                                last;
  logic [sca_pkg::StatW-1:0]           status;
  logic                                overflow;

  modport source (output valid, out_row, out_col, out_value, last, status, overflow,
                  input ready);
  modport sink   (input valid, out_row, out_col, out_value, last, status, overflow,
                  output ready);
endinterface

@@ sv/sparse_coo_matrix_add.sv @@
// ----------------------------------------------------------------------------
// sparse_coo_matrix_add
// Adds two sparse matrices held as row-major coordinate triplet lists.
// ----------------------------------------------------------------------------
// Usage:
// Input words carry a command. A load word appends (row, col, value) to list A
// or list B and produces no output, and loads can stream at one word per
// cycle between runs. A load into a full list is dropped and remembered.
// A start word merges both lists in row-major order and sends the sum's
// triplets on the output channel, the final one marked with last. A
// dimension mismatch or an empty sum gives a single status word instead.
// The first output word is registered once the run has begun and the output
// register can take it, and further words follow one per cycle while the
// receiver keeps up; the input stays blocked until the final word is
// registered, and that final word empties both lists. When the receiver
// stalls, the output register holds its word and the merge waits, so the
// input stays blocked for the stall as well; loads are taken while the last
// word of a run still waits.
// Reset clears the list counts, the drop flag, the dimension registers and
// the output valid; the list memories are not cleared and need no sweep.
// Dimension registers are written through cfg_we_i, cfg_idx_i, cfg_data_i.
// ----------------------------------------------------------------------------
`include "sparse_coo_matrix_add_assert.svh"

module sparse_coo_matrix_add #(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sca_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sca_pkg::CfgW-1:0]      cfg_data_i,
  sca_in_if.sink                        in_i,
  sca_out_if.source                     out_o
);

  localparam int unsigned CntW  = $clog2(MAX_TERMS + 1);
  localparam int unsigned AddrW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_TERMS);

  // Dimension registers.
  logic [sca_pkg::CfgW-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;

  // Sequencer and list bookkeeping.
  sca_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_a_q, count_a_d, count_b_q, count_b_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic            dropped_q, dropped_d;

  // List memories and their registered read data.
  sca_pkg::entry_t mem_a_q [MAX_TERMS];
  sca_pkg::entry_t mem_b_q [MAX_TERMS];
  sca_pkg::entry_t rd_a_q, rd_b_q;

  // Output register.
  logic                             out_valid_q;
  logic [sca_pkg::IdxW-1:0]         out_row_q, out_col_q;
  logic signed [sca_pkg::ValW-1:0]  out_value_q;
  logic                             out_last_q;
  logic [sca_pkg::StatW-1:0]        out_status_q;
  logic                             out_overflow_q;

  // Combinational control.
  logic                             in_fire, load_a, load_b, start;
  logic                             can_emit, emit;
  logic                             mismatch, a_ok, b_ok, take_a, take_b;
  logic [2*sca_pkg::IdxW-1:0]       key_a, key_b;
  logic signed [sca_pkg::ValW-1:0]  val_a, val_b, sum_sat;
  logic signed [sca_pkg::ValW:0]    sum_w;
  logic [CntW-1:0]                  i_n, j_n;
  sca_pkg::entry_t                  wr_entry;
  logic [sca_pkg::IdxW-1:0]         res_row, res_col;
  logic signed [sca_pkg::ValW-1:0]  res_value;
  logic                             res_last;
  logic [sca_pkg::StatW-1:0]        res_status;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= '0;
      cols_a_q <= '0;
      rows_b_q <= '0;
      cols_b_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sca_pkg::CFG_ROWS_A: rows_a_q <= cfg_data_i;
        sca_pkg::CFG_COLS_A: cols_a_q <= cfg_data_i;
        sca_pkg::CFG_ROWS_B: rows_b_q <= cfg_data_i;
        sca_pkg::CFG_COLS_B: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input decode: words are taken only between runs.
  assign in_i.ready = (state_q == sca_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign load_a     = in_fire && (in_i.cmd == sca_pkg::CMD_LOAD_A) && (count_a_q != CntMax);
  assign load_b     = in_fire && (in_i.cmd == sca_pkg::CMD_LOAD_B) && (count_b_q != CntMax);
  assign start      = in_fire && (in_i.cmd == sca_pkg::CMD_START);
  assign wr_entry   = '{row: in_i.row, col: in_i.col, value: in_i.value};

  // Merge compare: row-major order is the order of the {row, col} key.
  assign mismatch = (rows_a_q != rows_b_q) || (cols_a_q != cols_b_q);
  assign a_ok     = (i_q < count_a_q);
  assign b_ok     = (j_q < count_b_q);
  assign key_a    = {rd_a_q.row, rd_a_q.col};
  assign key_b    = {rd_b_q.row, rd_b_q.col};

  always_comb begin
    if (a_ok && b_ok) begin
      take_a = (key_a <= key_b);
      take_b = (key_b <= key_a);
    end else begin
      take_a = a_ok;
      take_b = b_ok;
    end
  end

  // Sum with saturation; a lone entry is added to zero.
  assign val_a   = take_a ? rd_a_q.value : '0;
  assign val_b   = take_b ? rd_b_q.value : '0;
  assign sum_w   = {val_a[sca_pkg::ValW-1], val_a} + {val_b[sca_pkg::ValW-1], val_b};
  assign sum_sat = (sum_w[sca_pkg::ValW] != sum_w[sca_pkg::ValW-1])
                 ? (sum_w[sca_pkg::ValW] ? sca_pkg::VAL_MIN : sca_pkg::VAL_MAX)
                 : sum_w[sca_pkg::ValW-1:0];
  assign i_n     = i_q + CntW'(take_a);
  assign j_n     = j_q + CntW'(take_b);

  assign can_emit = !out_valid_q || out_o.ready;
  assign emit     = (state_q == sca_pkg::ST_RUN) && can_emit;

  // Result selection for the current merge step.
  always_comb begin
    res_row    = '0;
    res_col    = '0;
    res_value  = '0;
    res_last   = 1'b1;
    res_status = sca_pkg::STAT_OK;
    priority if (mismatch) begin
      res_status = sca_pkg::STAT_DIM;
    end else if ((count_a_q == '0) && (count_b_q == '0)) begin
      res_status = sca_pkg::STAT_EMPTY;
    end else begin
      res_row   = take_a ? rd_a_q.row : rd_b_q.row;
      res_col   = take_a ? rd_a_q.col : rd_b_q.col;
      res_value = sum_sat;
      res_last  = (i_n == count_a_q) && (j_n == count_b_q);
    end
  end

  // Next state, list counts and read indexes.
  always_comb begin
    state_d   = state_q;
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    dropped_d = dropped_q;
    i_d       = i_q;
    j_d       = j_q;
    unique case (state_q)
      sca_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_i.cmd == sca_pkg::CMD_LOAD_A) begin
            if (load_a) count_a_d = count_a_q + CntW'(1);
            else        dropped_d = 1'b1;
          end
          if (in_i.cmd == sca_pkg::CMD_LOAD_B) begin
            if (load_b) count_b_d = count_b_q + CntW'(1);
            else        dropped_d = 1'b1;
          end
        end
        if (start) begin
          state_d = sca_pkg::ST_RUN;
          i_d     = '0;
          j_d     = '0;
        end
      end
      sca_pkg::ST_RUN: begin
        if (emit) begin
          i_d = i_n;
          j_d = j_n;
          if (res_last) begin
            state_d   = sca_pkg::ST_IDLE;
            count_a_d = '0;
            count_b_d = '0;
            dropped_d = 1'b0;
          end
        end
      end
      default: state_d = sca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sca_pkg::ST_IDLE;
      count_a_q <= '0;
      count_b_q <= '0;
      dropped_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
    end else begin
      state_q   <= state_d;
      count_a_q <= count_a_d;
      count_b_q <= count_b_d;
      dropped_q <= dropped_d;
      i_q       <= i_d;
      j_q       <= j_d;
    end
  end

  // List memories: write at the fill count, read at the next merge index.
  always_ff @(posedge clk_i) begin
    if (load_a) mem_a_q[count_a_q[AddrW-1:0]] <= wr_entry;
    if (load_b) mem_b_q[count_b_q[AddrW-1:0]] <= wr_entry;
    rd_a_q <= mem_a_q[i_d[AddrW-1:0]];
    rd_b_q <= mem_b_q[j_d[AddrW-1:0]];
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (can_emit) begin
      out_valid_q <= emit;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_row_q      <= res_row;
      out_col_q      <= res_col;
      out_value_q    <= res_value;
      out_last_q     <= res_last;
      out_status_q   <= res_status;
      out_overflow_q <= dropped_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_row   = out_row_q;
  assign out_o.out_col   = out_col_q;
  assign out_o.out_value = out_value_q;
  assign out_o.last      = out_last_q;
  assign out_o.status    = out_status_q;
  assign out_o.overflow  = out_overflow_q;

  // Checks on the sequencer and the lists.
  `SCA_ASSERT_SAME(a_count_bound, 1'b1, (count_a_q <= CntMax) && (count_b_q <= CntMax), "list count beyond capacity")
  `SCA_ASSERT_NEXT(a_run_clears, emit && res_last, (state_q == sca_pkg::ST_IDLE) && (count_a_q == '0) && (count_b_q == '0) && !dropped_q, "lists not emptied after the final word")
  `SCA_ASSERT_SAME(a_status_last, out_valid_q && (out_status_q != sca_pkg::STAT_OK), out_last_q, "status word without last")

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix adder testbench
// Loads coordinate lists into both stores and starts merges. It covers
// dimension mismatch, empty sums, saturation, zero sums and dropped loads,
// and then runs random well-formed lists mixed with noise. A predictor kept
// in step with every accepted input word queues the expected output words,
// and each accepted output word is compared field by field. Both channels
// stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned LIST_DEPTH = 16;
  localparam logic [sca_pkg::CmdW-1:0] CMD_NOP = 2'd3;  // unused command, ignored
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_WORDS = 360;
  localparam int CYCLE_LIMIT = 2000000;

  localparam logic [sca_pkg::CfgIdxW-1:0] REG_ORDER [4] = '{
    sca_pkg::CFG_ROWS_A, sca_pkg::CFG_COLS_A, sca_pkg::CFG_ROWS_B, sca_pkg::CFG_COLS_B
  };

  // One output word as the predictor expects it.
  typedef struct packed {
    logic [sca_pkg::IdxW-1:0]        row;
    logic [sca_pkg::IdxW-1:0]        col;
    logic signed [sca_pkg::ValW-1:0] value;
    logic                            last;
    logic [sca_pkg::StatW-1:0]       status;
    logic                            ovf;
  } sum_word_t;

  typedef enum logic {
    ROW_CFG,
    ROW_WORD
  } step_kind_e;

  // One row of the directed script. A register row carries its data in row.
  typedef struct packed {
    step_kind_e                      kind;
    logic [sca_pkg::CfgIdxW-1:0]     reg_idx;
    logic [sca_pkg::CmdW-1:0]        cmd;
    logic [sca_pkg::IdxW-1:0]        row;
    logic [sca_pkg::IdxW-1:0]        col;
    logic signed [sca_pkg::ValW-1:0] value;
    logic [4:0]                      reps;
    logic                            typed;
    sum_word_t                       want;
  } step_t;

  localparam sum_word_t NO_SUM = '0;
  localparam sum_word_t EMPTY_SUM = '{16'd0, 16'd0, 32'sd0, 1'b1, sca_pkg::STAT_EMPTY, 1'b0};
  localparam sum_word_t DIM_SUM = '{16'd0, 16'd0, 32'sd0, 1'b1, sca_pkg::STAT_DIM, 1'b0};
  localparam sum_word_t DIM_LOST_SUM = '{16'd0, 16'd0, 32'sd0, 1'b1, sca_pkg::STAT_DIM, 1'b1};

  // Directed script: status words are typed in, the merge run is predicted.
  localparam step_t SCRIPT [20] = '{
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_START, 16'd0, 16'd0, 32'sd0,
      5'd1, 1'b1, EMPTY_SUM},
    '{ROW_CFG, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_START, 16'hFFFF, 16'd0, 32'sd0,
      5'd1, 1'b0, NO_SUM},
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_START, 16'd0, 16'd0, 32'sd0,
      5'd1, 1'b1, DIM_SUM},
    '{ROW_CFG, sca_pkg::CFG_ROWS_B, sca_pkg::CMD_START, 16'hFFFF, 16'd0, 32'sd0,
      5'd1, 1'b0, NO_SUM},
    '{ROW_CFG, sca_pkg::CFG_COLS_A, sca_pkg::CMD_START, 16'hFFFF, 16'd0, 32'sd0,
      5'd1, 1'b0, NO_SUM},
    '{ROW_CFG, sca_pkg::CFG_COLS_B, sca_pkg::CMD_START, 16'hFFFF, 16'd0, 32'sd0,
      5'd1, 1'b0, NO_SUM},
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_LOAD_A, 16'd0, 16'd0, sca_pkg::VAL_MAX,
      5'd1, 1'b0, NO_SUM},
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_LOAD_A, 16'd1, 16'd2, 32'sd5,
      5'd1, 1'b0, NO_SUM},
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_LOAD_A, 16'hFFFF, 16'hFFFF,
      sca_pkg::VAL_MIN, 5'd1, 1'b0, NO_SUM},
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_LOAD_B, 16'd0, 16'd0, 32'sd1,
      5'd1, 1'b0, NO_SUM},
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_LOAD_B, 16'd1, 16'd2, -32'sd5,
      5'd1, 1'b0, NO_SUM},
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_LOAD_B, 16'd1, 16'd3, 32'sd7,
      5'd1, 1'b0, NO_SUM},
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_LOAD_B, 16'hFFFF, 16'hFFFF, -32'sd1,
      5'd1, 1'b0, NO_SUM},
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, CMD_NOP, 16'hFFFF, 16'hFFFF, -32'sd1,
      5'd1, 1'b0, NO_SUM},
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_START, 16'd0, 16'd0, 32'sd0,
      5'd1, 1'b0, NO_SUM},
    '{ROW_CFG, sca_pkg::CFG_COLS_B, sca_pkg::CMD_START, 16'd0, 16'd0, 32'sd0,
      5'd1, 1'b0, NO_SUM},
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_LOAD_B, 16'd2, 16'd0, 32'sd3,
      5'd17, 1'b0, NO_SUM},
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_START, 16'd0, 16'd0, 32'sd0,
      5'd1, 1'b1, DIM_LOST_SUM},
    '{ROW_CFG, sca_pkg::CFG_COLS_B, sca_pkg::CMD_START, 16'hFFFF, 16'd0, 32'sd0,
      5'd1, 1'b0, NO_SUM},
    '{ROW_WORD, sca_pkg::CFG_ROWS_A, sca_pkg::CMD_START, 16'd0, 16'd0, 32'sd0,
      5'd1, 1'b1, EMPTY_SUM}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [sca_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [sca_pkg::CfgW-1:0]      cfg_data_i;

  sca_in_if  in_if ();
  sca_out_if out_if ();

  sparse_coo_matrix_add #(
    .MAX_TERMS (LIST_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Predictor state: both lists, their counts, the drop flag and dimensions.
  sca_pkg::entry_t          list_a [LIST_DEPTH];
  sca_pkg::entry_t          list_b [LIST_DEPTH];
  int unsigned              n_a = 0;
  int unsigned              n_b = 0;
  logic                     lost = 1'b0;
  logic [sca_pkg::CfgW-1:0] dims [4] = '{default: '0};

  sum_word_t sums_due [$];
  sum_word_t head;
  int        errors = 0;
  int        sent_words = 0;
  int        source_calm = 0;
  int        sink_calm = 0;
  int        cycles = 0;

  // Clock with an 8 ns period.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [sca_pkg::ValW-1:0] got,
                             input logic [sca_pkg::ValW-1:0] want);
    if (got !== want) begin
      report($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Gap before the next word, drawn at random, with calm stretches of no gap.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
    end
    return $urandom_range(0, 11);
  endfunction

  // Values lean toward the saturation limits and small numbers.
  function automatic logic signed [sca_pkg::ValW-1:0] draw_value();
    case ($urandom_range(0, 7))
      0: begin
        return sca_pkg::VAL_MAX;
      end
      1: begin
        return sca_pkg::VAL_MIN;
      end
      2: begin
        return $signed(32'($urandom_range(0, 20))) - 32'sd10;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  function automatic sca_pkg::entry_t random_entry();
    return sca_pkg::entry_t'{16'($urandom), 16'($urandom), draw_value()};
  endfunction

  // Advances the predictor by one accepted word and queues the sum words
  // that a start produces. A typed word stands in for the predicted one.
  function automatic void predict_word(logic [sca_pkg::CmdW-1:0] cmd,
                                       logic [sca_pkg::IdxW-1:0] row,
                                       logic [sca_pkg::IdxW-1:0] col,
                                       logic signed [sca_pkg::ValW-1:0] value,
                                       logic typed, sum_word_t want);
    sum_word_t                       run_words [$];
    sca_pkg::entry_t                 ea;
    sca_pkg::entry_t                 eb;
    int unsigned                     ia;
    int unsigned                     ib;
    logic signed [sca_pkg::ValW:0]   total;
    logic signed [sca_pkg::ValW-1:0] clamped;

    case (cmd)
      sca_pkg::CMD_LOAD_A: begin
        if (n_a >= LIST_DEPTH) begin
          lost = 1'b1;
        end else begin
          list_a[n_a] = sca_pkg::entry_t'{row, col, value};
          n_a++;
        end
      end
      sca_pkg::CMD_LOAD_B: begin
        if (n_b >= LIST_DEPTH) begin
          lost = 1'b1;
        end else begin
          list_b[n_b] = sca_pkg::entry_t'{row, col, value};
          n_b++;
        end
      end
      sca_pkg::CMD_START: begin
        if (dims[sca_pkg::CFG_ROWS_A] != dims[sca_pkg::CFG_ROWS_B] ||
            dims[sca_pkg::CFG_COLS_A] != dims[sca_pkg::CFG_COLS_B]) begin
          run_words.push_back(sum_word_t'{16'd0, 16'd0, 32'sd0, 1'b0, sca_pkg::STAT_DIM,
                                          lost});
        end else begin
          ia = 0;
          ib = 0;
          // Row-major merge; equal coordinates fold into one saturated sum.
          while (ia < n_a || ib < n_b) begin
            if (ia < n_a) ea = list_a[ia];
            if (ib < n_b) eb = list_b[ib];
            if (ib == n_b || (ia < n_a && {ea.row, ea.col} < {eb.row, eb.col})) begin
              run_words.push_back(sum_word_t'{ea.row, ea.col, ea.value, 1'b0,
                                              sca_pkg::STAT_OK, lost});
              ia++;
            end else if (ia == n_a || {ea.row, ea.col} > {eb.row, eb.col}) begin
              run_words.push_back(sum_word_t'{eb.row, eb.col, eb.value, 1'b0,
                                              sca_pkg::STAT_OK, lost});
              ib++;
            end else begin
              total = ea.value + eb.value;
              if (total > sca_pkg::VAL_MAX) begin
                clamped = sca_pkg::VAL_MAX;
              end else if (total < sca_pkg::VAL_MIN) begin
                clamped = sca_pkg::VAL_MIN;
              end else begin
                clamped = total[sca_pkg::ValW-1:0];
              end
              run_words.push_back(sum_word_t'{ea.row, ea.col, clamped, 1'b0,
                                              sca_pkg::STAT_OK, lost});
              ia++;
              ib++;
            end
          end
          if (run_words.size() == 0) begin
            run_words.push_back(sum_word_t'{16'd0, 16'd0, 32'sd0, 1'b0, sca_pkg::STAT_EMPTY,
                                            lost});
          end
        end
        run_words[run_words.size() - 1].last = 1'b1;
        n_a = 0;
        n_b = 0;
        lost = 1'b0;
        if (typed) begin
          sums_due.push_back(want);
        end else begin
          foreach (run_words[k]) sums_due.push_back(run_words[k]);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Drops valid and waits until every expected word has arrived.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the selected dimension registers while the block is idle.
  task automatic program_regs(input logic [3:0] mask,
                              input logic [sca_pkg::CfgW-1:0] vals [4]);
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= REG_ORDER[i];
        cfg_data_i <= vals[i];
        dims[REG_ORDER[i]] = vals[i];
        @(posedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // Offers one input word after a random gap and waits for its handshake.
  task automatic send_word(input logic [sca_pkg::CmdW-1:0] cmd,
                           input logic [sca_pkg::IdxW-1:0] row,
                           input logic [sca_pkg::IdxW-1:0] col,
                           input logic signed [sca_pkg::ValW-1:0] value,
                           input logic typed, input sum_word_t want);
    int gap;
    gap = draw_wait(source_calm);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.row   <= row;
    in_if.col   <= col;
    in_if.value <= value;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_word(cmd, row, col, value, typed, want);
    if (cmd != CMD_NOP) sent_words++;
  endtask

  // One random run: dimensions, both lists, then a start.
  task automatic run_phase();
    sca_pkg::entry_t                 a_q [$];
    sca_pkg::entry_t                 b_q [$];
    sca_pkg::entry_t                 e;
    logic [sca_pkg::CfgW-1:0]        regs [4];
    int unsigned                     ri;
    int unsigned                     ci;
    int unsigned                     step;
    int                              mode;
    int                              pick;
    int                              coords;
    int                              extra;
    bit                              wide;
    bit                              to_a;
    logic signed [sca_pkg::ValW-1:0] va;

    // Dimensions: mostly matching, sometimes extremes, kept or mismatched.
    wide = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 9))
      0: begin
        regs[0] = 16'($urandom);
        regs[1] = 16'($urandom);
        regs[2] = regs[0];
        regs[3] = regs[1];
        if ($urandom_range(0, 1) == 1) begin
          regs[2] = regs[0] + 16'($urandom_range(1, 65535));
        end else begin
          regs[3] = regs[1] + 16'($urandom_range(1, 65535));
        end
        program_regs(4'hF, regs);
      end
      1, 2: begin
        if ($urandom_range(0, 1) == 1) wait_idle();
      end
      3: begin
        if ($urandom_range(0, 1) == 1) begin
          regs = '{default: 16'hFFFF};
        end else begin
          regs = '{default: 16'h0};
        end
        program_regs(4'hF, regs);
      end
      default: begin
        regs[0] = wide ? 16'($urandom) : 16'($urandom_range(1, 8));
        regs[1] = wide ? 16'($urandom) : 16'($urandom_range(1, 8));
        regs[2] = regs[0];
        regs[3] = regs[1];
        program_regs(4'hF, regs);
      end
    endcase

    // Lists: mostly row-major with shared coordinates, some noise or overfill.
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(0, 18)) a_q.push_back(random_entry());
      repeat ($urandom_range(0, 18)) b_q.push_back(random_entry());
    end else begin
      ri = wide ? $urandom_range(0, 65535) : $urandom_range(0, 3);
      ci = wide ? $urandom_range(0, 65535) : $urandom_range(0, 7);
      coords = $urandom_range(0, 16);
      while (coords > 0) begin
        coords--;
        pick = $urandom_range(0, 2);
        va = draw_value();
        if (pick != 1 && a_q.size() < LIST_DEPTH) begin
          a_q.push_back(sca_pkg::entry_t'{16'(ri), 16'(ci), va});
        end
        if (pick != 0 && b_q.size() < LIST_DEPTH) begin
          if (pick == 2 && $urandom_range(0, 3) == 0) begin
            b_q.push_back(sca_pkg::entry_t'{16'(ri), 16'(ci), -va});
          end else begin
            b_q.push_back(sca_pkg::entry_t'{16'(ri), 16'(ci), draw_value()});
          end
        end
        // Next coordinate: further along the row, or onto a later row.
        step = wide ? $urandom_range(1, 8192) : $urandom_range(1, 3);
        if ($urandom_range(0, 2) != 0 && ci + step <= 65535) begin
          ci += step;
        end else begin
          step = wide ? $urandom_range(1, 8192) : $urandom_range(1, 2);
          if (ri + step > 65535) begin
            coords = 0;
          end else begin
            ri += step;
            ci = wide ? $urandom_range(0, 65535) : $urandom_range(0, 7);
          end
        end
      end
      if (mode == 1) begin
        extra = $urandom_range(1, 4);
        if ($urandom_range(0, 1) == 1) begin
          while (a_q.size() < LIST_DEPTH + extra) a_q.push_back(random_entry());
        end else begin
          while (b_q.size() < LIST_DEPTH + extra) b_q.push_back(random_entry());
        end
      end
    end

    // Interleave the two lists, with the odd unused command among them.
    while (a_q.size() + b_q.size() != 0) begin
      if ($urandom_range(0, 15) == 0) begin
        send_word(CMD_NOP, 16'($urandom), 16'($urandom), $urandom, 1'b0, NO_SUM);
      end
      to_a = (b_q.size() == 0) || (a_q.size() != 0 && $urandom_range(0, 1) == 1);
      if (to_a) begin
        e = a_q.pop_front();
        send_word(sca_pkg::CMD_LOAD_A, e.row, e.col, e.value, 1'b0, NO_SUM);
      end else begin
        e = b_q.pop_front();
        send_word(sca_pkg::CMD_LOAD_B, e.row, e.col, e.value, 1'b0, NO_SUM);
      end
    end
    send_word(sca_pkg::CMD_START, 16'($urandom), 16'($urandom), $urandom, 1'b0, NO_SUM);
  endtask

  // Output side: stall at random, then take one word.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(sink_calm);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
    end
  end

  // Compare every accepted output word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (sums_due.size() == 0) begin
        report($sformatf("unexpected word row %0h col %0h status %0h",
                         out_if.out_row, out_if.out_col, out_if.status));
      end else begin
        head = sums_due.pop_front();
        check_field("out_row", out_if.out_row, head.row);
        check_field("out_col", out_if.out_col, head.col);
        check_field("out_value", out_if.out_value, head.value);
        check_field("last", out_if.last, head.last);
        check_field("status", out_if.status, head.status);
        check_field("overflow", out_if.overflow, head.ovf);
      end
    end
  end

  // Reset, directed script, random runs, then drain.
  initial begin
    int                       base;
    logic [sca_pkg::CfgW-1:0] regs [4];
    step_t                    s;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= sca_pkg::CFG_ROWS_A;
    cfg_data_i  <= '0;
    in_if.valid <= 1'b0;
    in_if.cmd   <= sca_pkg::CMD_LOAD_A;
    in_if.row   <= '0;
    in_if.col   <= '0;
    in_if.value <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (SCRIPT[i]) begin
      s = SCRIPT[i];
      if (s.kind == ROW_CFG) begin
        regs = '{default: s.row};
        program_regs(4'b0001 << s.reg_idx, regs);
      end else begin
        for (int k = 0; k < s.reps; k++) begin
          send_word(s.cmd, s.row, s.col + sca_pkg::IdxW'(k), s.value, s.typed, s.want);
        end
      end
    end

    base = sent_words;
    while (sent_words - base < RANDOM_WORDS) run_phase();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
